// ===== hdl/abrf_pkg.sv =====
// shared types, mode codes and helpers for the banked register file
package abrf_pkg;

	typedef enum logic [2:0] {
		OP_READ_REG    = 3'd0,
		OP_WRITE_REG   = 3'd1,
		OP_SET_MODE    = 3'd2,
		OP_READ_STATUS = 3'd3,
		OP_WRITE_SPSR  = 3'd4,
		OP_READ_SPSR   = 3'd5
	} op_t;

	localparam logic [4:0] MODE_USER = 5'h10;
	localparam logic [4:0] MODE_FIQ  = 5'h11;
	localparam logic [4:0] MODE_IRQ  = 5'h12;
	localparam logic [4:0] MODE_SVC  = 5'h13;
	localparam logic [4:0] MODE_ABT  = 5'h17;
	localparam logic [4:0] MODE_UND  = 5'h1B;
	localparam logic [4:0] MODE_SYS  = 5'h1F;

	localparam logic [31:0] STATUS_RESET = 32'h0000_00D3;

	localparam logic [2:0] BANK_USER = 3'd0;
	localparam logic [2:0] BANK_FIQ  = 3'd1;
	localparam logic [2:0] BANK_IRQ  = 3'd2;
	localparam logic [2:0] BANK_SVC  = 3'd3;
	localparam logic [2:0] BANK_ABT  = 3'd4;
	localparam logic [2:0] BANK_UND  = 3'd5;
	localparam logic [2:0] BANK_NONE = 3'd6;

	localparam int NUM_BANKS  = 6;
	localparam int FIQ_COPIES = 7;
	localparam int USR_COPIES = 5;

	typedef struct packed {
		logic        valid;
		op_t         op;
		logic [3:0]  idx;
		logic [31:0] data;
		logic [4:0]  mode;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bad_mode;
	} rsp_t;

	function automatic logic [2:0] bank_of_mode(input logic [4:0] code);
		logic [2:0] bank;
		case (code)
			MODE_USER, MODE_SYS: bank = BANK_USER;
			MODE_FIQ:            bank = BANK_FIQ;
			MODE_IRQ:            bank = BANK_IRQ;
			MODE_SVC:            bank = BANK_SVC;
			MODE_ABT:            bank = BANK_ABT;
			MODE_UND:            bank = BANK_UND;
			default:             bank = BANK_NONE;
		endcase
		return bank;
	endfunction

endpackage

// ===== hdl/abrf_regs.sv =====
// architectural register state, mode banking and the register access logic
module abrf_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  abrf_pkg::req_t req,
	output abrf_pkg::rsp_t rsp
);

	logic [31:0] vis_q  [16];
	logic [31:0] fiq_q  [abrf_pkg::FIQ_COPIES];
	logic [31:0] usr_q  [abrf_pkg::USR_COPIES];
	logic [31:0] sp_q   [abrf_pkg::NUM_BANKS];
	logic [31:0] lr_q   [abrf_pkg::NUM_BANKS];
	logic [31:0] spsr_q [abrf_pkg::NUM_BANKS];
	logic [4:0]  mode_q;

	logic [2:0] from_bank;
	logic [2:0] to_bank;
	logic       mode_ok;
	logic       mode_change;
	logic       leave_fiq;
	logic       enter_fiq;
	logic       spsr_ok;

	assign from_bank   = abrf_pkg::bank_of_mode(mode_q);
	assign to_bank     = abrf_pkg::bank_of_mode(req.mode);
	assign mode_ok     = (to_bank != abrf_pkg::BANK_NONE) && (from_bank != abrf_pkg::BANK_NONE);
	assign mode_change = req.valid && (req.op == abrf_pkg::OP_SET_MODE) && mode_ok
		&& (req.mode != mode_q);
	assign leave_fiq   = (mode_q == abrf_pkg::MODE_FIQ);
	assign enter_fiq   = (req.mode == abrf_pkg::MODE_FIQ);
	// user and system modes have no saved status
	assign spsr_ok     = (from_bank != abrf_pkg::BANK_USER) && (from_bank != abrf_pkg::BANK_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) vis_q[i] <= '0;
			for (int i = 0; i < abrf_pkg::FIQ_COPIES; i++) fiq_q[i] <= '0;
			for (int i = 0; i < abrf_pkg::USR_COPIES; i++) usr_q[i] <= '0;
			for (int i = 0; i < abrf_pkg::NUM_BANKS; i++) begin
				sp_q[i]   <= '0;
				lr_q[i]   <= '0;
				spsr_q[i] <= '0;
			end
			mode_q <= abrf_pkg::STATUS_RESET[4:0];
		end else if (req.valid) begin
			case (req.op)
				abrf_pkg::OP_WRITE_REG: begin
					vis_q[req.idx] <= req.data;
				end
				abrf_pkg::OP_WRITE_SPSR: begin
					if (spsr_ok) spsr_q[from_bank] <= req.data;
				end
				abrf_pkg::OP_SET_MODE: begin
					if (mode_change) begin
						sp_q[from_bank] <= vis_q[13];
						lr_q[from_bank] <= vis_q[14];
						if (leave_fiq) begin
							for (int i = 0; i < abrf_pkg::FIQ_COPIES; i++)
								fiq_q[i] <= vis_q[8 + i];
							for (int i = 0; i < abrf_pkg::USR_COPIES; i++)
								vis_q[8 + i] <= usr_q[i];
						end else if (enter_fiq) begin
							for (int i = 0; i < abrf_pkg::USR_COPIES; i++)
								usr_q[i] <= vis_q[8 + i];
							for (int i = 0; i < abrf_pkg::FIQ_COPIES; i++)
								vis_q[8 + i] <= fiq_q[i];
						end
						// fiq takes r13/r14 from its own copy; same bank keeps them
						if (!enter_fiq && (from_bank != to_bank)) begin
							vis_q[13] <= sp_q[to_bank];
							vis_q[14] <= lr_q[to_bank];
						end
						mode_q <= req.mode;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		rsp.read_data = '0;
		rsp.bad_mode  = 1'b0;
		case (req.op)
			abrf_pkg::OP_READ_REG:    rsp.read_data = vis_q[req.idx];
			abrf_pkg::OP_READ_STATUS: rsp.read_data = {abrf_pkg::STATUS_RESET[31:5], mode_q};
			abrf_pkg::OP_READ_SPSR: begin
				if (spsr_ok) rsp.read_data = spsr_q[from_bank];
			end
			abrf_pkg::OP_SET_MODE:    rsp.bad_mode = !mode_ok;
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/arm_banked_register_file.sv =====
// Banked register file: sixteen visible 32-bit registers with per-mode r13/r14, a fast
// interrupt copy of r8..r14 and a saved status word per exception mode. A request is
// captured in an input register, executed against the register state as it leaves
// that register, and its result lands in an output register; one request is taken
// every cycle while in_stall is low. A mode switch copies the banked registers as it
// executes. in_stall rises only while the output register is full and stalled with a
// request waiting in the input register.
module arm_banked_register_file (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [3:0]  reg_index,
	input  logic [31:0] write_data,
	input  logic [4:0]  target_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        bad_mode
);

	abrf_pkg::req_t req_s1;
	abrf_pkg::req_t exec_req;
	abrf_pkg::rsp_t exec_rsp;
	abrf_pkg::rsp_t rsp_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic           advance;
	logic           accept;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) valid_s2 <= 1'b1;
			else if (!out_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.valid <= 1'b1;
			req_s1.op    <= abrf_pkg::op_t'(opcode);
			req_s1.idx   <= reg_index;
			req_s1.data  <= write_data;
			req_s1.mode  <= target_mode;
		end
		if (advance) rsp_s2 <= exec_rsp;
	end

	always_comb begin
		exec_req       = req_s1;
		exec_req.valid = advance;
	end

	abrf_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (exec_req),
		.rsp    (exec_rsp)
	);

	assign out_valid = valid_s2;
	assign read_data = rsp_s2.read_data;
	assign bad_mode  = rsp_s2.bad_mode;

endmodule

// ===== hdl/abrf_checker.sv =====
// port-level checks for the banked register file and their bind
module abrf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] read_data,
	input logic        bad_mode
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(bad_mode))
		else $error("result changed while stalled");

	// back-pressure only comes from a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// a refused mode switch reads nothing
	a_bad_mode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_mode |-> read_data == 32'h0)
		else $error("bad mode result carries data");

	// an empty output never stalls the input
	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

endmodule

bind arm_banked_register_file abrf_checker u_abrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.read_data (read_data),
	.bad_mode  (bad_mode)
);
